// ===== src/pws_pkg.sv =====
// ----------------------------------------------------------------------------
// pws_pkg
// Shared types, sizes and the letter decoder of the window scorer.
// ----------------------------------------------------------------------------
package pws_pkg;

    // Score table geometry.
    localparam int MAX_COLUMNS      = 64;
    localparam int SLOTS_PER_COLUMN = 21;
    localparam int TABLE_DEPTH      = MAX_COLUMNS * SLOTS_PER_COLUMN;
    localparam int TABLE_AW         = $clog2(TABLE_DEPTH);
    localparam int COL_W            = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // Field widths.
    localparam int SLOT_W  = 5;
    localparam int SCORE_W = 16;
    localparam int SYM_W   = 8;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = 24;

    // Alphabet sizes; the wildcard slot equals the alphabet size.
    localparam logic [SLOT_W-1:0] AMINO_SIZE = 5'd20;
    localparam logic [SLOT_W-1:0] NUC_SIZE   = 5'd4;

    localparam logic [SYM_W-1:0] STOP_CHAR = 8'h2A;

    // Commands carried in tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SCORE = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_NUC_MODE  = 2'd0;
    localparam logic [1:0] REG_COL_COUNT = 2'd1;
    localparam logic [1:0] REG_STOP      = 2'd2;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One scored column on its way to the accumulator.
    typedef struct packed {
        logic signed [SCORE_W-1:0] add;
        logic                      last;
    } t_job;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_letter;

    // Maps a character to its slot in the active alphabet; lowercase folds
    // to uppercase, and U counts as T for nucleotides.
    function automatic t_letter letter_of(input logic [SYM_W-1:0] sym, input logic nuc);
        logic [SYM_W-1:0] up;
        t_letter          res;
        up  = (sym >= 8'h61 && sym <= 8'h7A) ? sym - 8'd32 : sym;
        res = '{hit: 1'b1, slot: '0};
        if (nuc) begin
            case (up)
                8'h41:   res.slot = 5'd0;  // A
                8'h43:   res.slot = 5'd1;  // C
                8'h47:   res.slot = 5'd2;  // G
                8'h54,
                8'h55:   res.slot = 5'd3;  // T, U
                default: res.hit  = 1'b0;
            endcase
        end else begin
            case (up)
                8'h41:   res.slot = 5'd0;  // A
                8'h43:   res.slot = 5'd1;  // C
                8'h44:   res.slot = 5'd2;  // D
                8'h45:   res.slot = 5'd3;  // E
                8'h46:   res.slot = 5'd4;  // F
                8'h47:   res.slot = 5'd5;  // G
                8'h48:   res.slot = 5'd6;  // H
                8'h49:   res.slot = 5'd7;  // I
                8'h4B:   res.slot = 5'd8;  // K
                8'h4C:   res.slot = 5'd9;  // L
                8'h4D:   res.slot = 5'd10; // M
                8'h4E:   res.slot = 5'd11; // N
                8'h50:   res.slot = 5'd12; // P
                8'h51:   res.slot = 5'd13; // Q
                8'h52:   res.slot = 5'd14; // R
                8'h53:   res.slot = 5'd15; // S
                8'h54:   res.slot = 5'd16; // T
                8'h56:   res.slot = 5'd17; // V
                8'h57:   res.slot = 5'd18; // W
                8'h59:   res.slot = 5'd19; // Y
                default: res.hit  = 1'b0;
            endcase
        end
        return res;
    endfunction

endpackage

// ===== src/pws_ram.sv =====
// ----------------------------------------------------------------------------
// pws_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1344
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pws_front.sv =====
// ----------------------------------------------------------------------------
// pws_front
// Accepts items, writes table entries, tracks the window column and reads
// the score of each character from the table.
// ----------------------------------------------------------------------------
module pws_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input item
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_command,
    input  logic [pws_pkg::COL_W-1:0]           i_load_column,
    input  logic [pws_pkg::SLOT_W-1:0]          i_letter_slot,
    input  logic [pws_pkg::SCORE_W-1:0]         i_score_value,
    input  logic [pws_pkg::SYM_W-1:0]           i_symbol,
    // Configuration
    input  logic                                i_nuc_mode,
    input  logic [pws_pkg::COUNT_W-1:0]         i_col_count,
    input  logic signed [pws_pkg::SCORE_W-1:0]  i_stop_score,
    // Queue side
    input  logic [pws_pkg::QUEUE_AW:0]          i_queue_level,
    output logic                                o_job_valid,
    output pws_pkg::t_job                       o_job
);

    logic                               r_stage_v;
    logic                               r_stage_stop;
    logic                               r_stage_last;
    logic [pws_pkg::COL_W-1:0]          r_col;
    logic [pws_pkg::COL_W-1:0]          n_col;

    logic                               accept;
    logic                               is_score;
    logic                               we;
    logic [pws_pkg::TABLE_AW-1:0]       waddr;
    logic [pws_pkg::TABLE_AW-1:0]       raddr;
    logic [pws_pkg::SLOT_W-1:0]         rslot;
    logic [pws_pkg::SCORE_W-1:0]        rdata;
    logic [pws_pkg::COUNT_W-1:0]        count_eff;
    logic                               last;
    logic                               is_stop;
    pws_pkg::t_letter                   letter;

    // Room for the item in flight plus the queue contents.
    assign o_ready  = (32'(i_queue_level) + 32'(r_stage_v)) < pws_pkg::QUEUE_DEPTH;
    assign accept   = i_valid && o_ready;
    assign is_score = (i_command == pws_pkg::CMD_SCORE);

    // Table write for load items inside the table.
    assign we    = accept && !is_score
                   && (32'(i_letter_slot) < pws_pkg::SLOTS_PER_COLUMN);
    assign waddr = pws_pkg::TABLE_AW'(i_load_column) * pws_pkg::TABLE_AW'(pws_pkg::SLOTS_PER_COLUMN)
                   + pws_pkg::TABLE_AW'(i_letter_slot);

    // Slot of the character: its letter, else the wildcard slot.
    assign is_stop = (i_symbol == pws_pkg::STOP_CHAR);
    assign letter  = pws_pkg::letter_of(i_symbol, i_nuc_mode);
    assign rslot   = letter.hit ? letter.slot
                   : (i_nuc_mode ? pws_pkg::NUC_SIZE : pws_pkg::AMINO_SIZE);
    assign raddr   = pws_pkg::TABLE_AW'(r_col) * pws_pkg::TABLE_AW'(pws_pkg::SLOTS_PER_COLUMN)
                   + pws_pkg::TABLE_AW'(rslot);

    // Window length, clamped into 1..MAX_COLUMNS.
    always_comb begin
        count_eff = i_col_count;
        if (i_col_count == '0) begin
            count_eff = pws_pkg::COUNT_W'(1);
        end else if (32'(i_col_count) > pws_pkg::MAX_COLUMNS) begin
            count_eff = pws_pkg::COUNT_W'(pws_pkg::MAX_COLUMNS);
        end
    end

    assign last  = (32'(r_col) + 1) >= 32'(count_eff);
    assign n_col = last ? '0 : r_col + pws_pkg::COL_W'(1);

    pws_ram #(
        .WIDTH (pws_pkg::SCORE_W),
        .DEPTH (pws_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_score_value),
        .i_re    (accept && is_score),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Column counter and the read stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_stage_v <= 1'b0;
        end else begin
            r_stage_v <= accept && is_score;
            if (accept && is_score) begin
                r_col <= n_col;
            end
        end
        if (accept && is_score) begin
            r_stage_stop <= is_stop;
            r_stage_last <= last;
        end
    end

    assign o_job_valid = r_stage_v;
    assign o_job.add   = r_stage_stop ? i_stop_score : signed'(rdata);
    assign o_job.last  = r_stage_last;

endmodule

// ===== src/pws_queue.sv =====
// ----------------------------------------------------------------------------
// pws_queue
// Small FIFO of scored columns between the front and the accumulator.
// ----------------------------------------------------------------------------
module pws_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  pws_pkg::t_job               i_job,
    input  logic                        i_pop,
    output logic                        o_valid,
    output pws_pkg::t_job               o_job,
    output logic [pws_pkg::QUEUE_AW:0]  o_level
);

    pws_pkg::t_job                  r_mem [pws_pkg::QUEUE_DEPTH];
    logic [pws_pkg::QUEUE_AW-1:0]   r_wr;
    logic [pws_pkg::QUEUE_AW-1:0]   r_rd;
    logic [pws_pkg::QUEUE_AW:0]     r_count;
    logic                           do_pop;

    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rd];
    assign o_level = r_count;

    // Pointers and fill level; the front never pushes into a full queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (32'(r_wr) == pws_pkg::QUEUE_DEPTH - 1) ? '0
                                                                : r_wr + pws_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= (32'(r_rd) == pws_pkg::QUEUE_DEPTH - 1) ? '0
                                                                : r_rd + pws_pkg::QUEUE_AW'(1);
            end
            r_count <= r_count + (pws_pkg::QUEUE_AW+1)'(i_push)
                               - (pws_pkg::QUEUE_AW+1)'(do_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== src/pws_back.sv =====
// ----------------------------------------------------------------------------
// pws_back
// Saturating window accumulator with the output register.
// ----------------------------------------------------------------------------
module pws_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  pws_pkg::t_job                     i_job,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [pws_pkg::SUM_W-1:0]  o_window_score,
    output logic                              o_saturated
);

    localparam logic signed [pws_pkg::SUM_W:0] SUM_MAX = (pws_pkg::SUM_W+1)'(8388607);
    localparam logic signed [pws_pkg::SUM_W:0] SUM_MIN = -(pws_pkg::SUM_W+1)'(8388608);

    logic signed [pws_pkg::SUM_W-1:0] r_sum;
    logic                             r_ovf;
    logic                             r_out_v;
    logic signed [pws_pkg::SUM_W-1:0] r_out_score;
    logic                             r_out_sat;

    logic signed [pws_pkg::SUM_W:0]   wide;
    logic signed [pws_pkg::SUM_W-1:0] n_sum;
    logic                             clamp;

    // Pop unless a finished window would overwrite an untaken result.
    assign o_pop = i_valid && (!i_job.last || !r_out_v || i_ready);

    // Saturating add of one column.
    always_comb begin
        wide  = (pws_pkg::SUM_W+1)'(r_sum) + (pws_pkg::SUM_W+1)'(i_job.add);
        clamp = 1'b1;
        if (wide > SUM_MAX) begin
            n_sum = SUM_MAX[pws_pkg::SUM_W-1:0];
        end else if (wide < SUM_MIN) begin
            n_sum = SUM_MIN[pws_pkg::SUM_W-1:0];
        end else begin
            n_sum = wide[pws_pkg::SUM_W-1:0];
            clamp = 1'b0;
        end
    end

    // Running sum and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if (o_pop) begin
                if (i_job.last) begin
                    r_sum   <= '0;
                    r_ovf   <= 1'b0;
                    r_out_v <= 1'b1;
                end else begin
                    r_sum <= n_sum;
                    r_ovf <= r_ovf | clamp;
                end
            end
        end
        if (o_pop && i_job.last) begin
            r_out_score <= n_sum;
            r_out_sat   <= r_ovf | clamp;
        end
    end

    assign o_valid        = r_out_v;
    assign o_window_score = r_out_score;
    assign o_saturated    = r_out_sat;

endmodule

// ===== src/pssm_window_scorer_core.sv =====
// ----------------------------------------------------------------------------
// pssm_window_scorer_core
// Scores windows of sequence characters against a loaded score table.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel. tuser carries the command: a load item
// writes one Q7.8 table entry, a score item scores one ASCII character at the
// current column. After column_count score items the m_axis channel returns
// the saturated Q15.8 window total in tdata and the saturation flag in tuser.
// Registers are to be written over the APB port only while the block is idle; the block itself does not enforce this.
// Throughput is one item per clock while s_axis_tready is high; the table RAM gives one read per cycle.
// A window result follows its last accepted character in order: the
// accepting edge reads the table, the read stage writes the queue, and
// the accumulator pops the entry, adds it into the sum and loads the output.
// The front stops taking items only when the four-entry queue and the read
// stage together hold four items, which happens when the receiver stalls.
// Reset clears the column, the running sum and the registers (column count
// one, amino acid alphabet, stop score zero); the table is not cleared and
// its entries must be loaded before they are scored.
// ----------------------------------------------------------------------------
module pssm_window_scorer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] load_column, [10:6] letter_slot, [26:11] score_value,
    // [34:27] symbol, [39:35] zero
    input  logic [39:0] s_axis_tdata,
    // [0] command
    input  logic [0:0]  s_axis_tuser,
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [23:0] window_score
    output logic [23:0] m_axis_tdata,
    // [0] saturated
    output logic [0:0]  m_axis_tuser,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                                r_nuc_mode;
    logic [pws_pkg::COUNT_W-1:0]         r_col_count;
    logic signed [pws_pkg::SCORE_W-1:0]  r_stop_score;

    logic [1:0]                          reg_idx;
    logic                                job_valid;
    pws_pkg::t_job                       job;
    logic                                q_valid;
    pws_pkg::t_job                       q_job;
    logic                                q_pop;
    logic [pws_pkg::QUEUE_AW:0]          q_level;
    logic signed [pws_pkg::SUM_W-1:0]    window_score;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nuc_mode   <= 1'b0;
            r_col_count  <= pws_pkg::COUNT_W'(1);
            r_stop_score <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                pws_pkg::REG_NUC_MODE:  r_nuc_mode   <= pwdata[0];
                pws_pkg::REG_COL_COUNT: r_col_count  <= pwdata[pws_pkg::COUNT_W-1:0];
                pws_pkg::REG_STOP:      r_stop_score <= signed'(pwdata[pws_pkg::SCORE_W-1:0]);
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_idx)
            pws_pkg::REG_NUC_MODE:  prdata = {31'd0, r_nuc_mode};
            pws_pkg::REG_COL_COUNT: prdata = 32'(r_col_count);
            pws_pkg::REG_STOP:      prdata = 32'(unsigned'(r_stop_score));
            default:                prdata = '0;
        endcase
    end

    pws_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_command     (s_axis_tuser[0]),
        .i_load_column (s_axis_tdata[5:0]),
        .i_letter_slot (s_axis_tdata[10:6]),
        .i_score_value (s_axis_tdata[26:11]),
        .i_symbol      (s_axis_tdata[34:27]),
        .i_nuc_mode    (r_nuc_mode),
        .i_col_count   (r_col_count),
        .i_stop_score  (r_stop_score),
        .i_queue_level (q_level),
        .o_job_valid   (job_valid),
        .o_job         (job)
    );

    pws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_level (q_level)
    );

    pws_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_job          (q_job),
        .o_pop          (q_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_window_score (window_score),
        .o_saturated    (m_axis_tuser[0])
    );

    assign m_axis_tdata = unsigned'(window_score);

endmodule
